// ===== hdl/sfwr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfwr_pkg
// Shared types, constants and table functions of the waterfall row engine.
// ----------------------------------------------------------------------------
package sfwr_pkg;

  localparam int FftSize    = 64;
  localparam int AddrW      = 6;
  localparam int HalfW      = 5;
  localparam int StageW     = 3;
  localparam int SampleBits = 16;
  localparam int WorkW      = 25;
  localparam int CoefW      = 17;
  localparam int PowW       = 51;
  localparam int MantW      = 31;
  localparam int FracW      = 12;
  localparam int ExpW       = 6;
  localparam int LogW       = ExpW + FracW;
  localparam int ScaleW     = 40;
  localparam int HopW       = 7;
  localparam int CntW       = 7;
  localparam int OffW       = 9;
  localparam int LevelW     = 8;
  localparam int IterW      = 4;

  localparam logic [IterW-1:0]  LogLast    = IterW'(FracW - 1);
  localparam logic [StageW-1:0] StageLast  = StageW'(AddrW - 1);
  localparam logic [HopW-1:0]   HopReset   = 7'd16;
  localparam logic [OffW-1:0]   OffReset   = 9'd36;
  localparam logic [21:0]       Db16Q16    = 22'd3156528;
  // 2*(SampleBits-1) * 4096 * Db16Q16
  localparam longint            DbBase     = longint'(2 * (SampleBits - 1)) * 4096 * 3156528;

  typedef enum logic [0:0] {
    REG_HOP    = 1'b0,
    REG_OFFSET = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_WIN_RD,
    OP_WIN_WR,
    OP_BF_RD,
    OP_BF_MUL,
    OP_BF_WRA,
    OP_BF_WRB,
    OP_OUT_RD,
    OP_OUT_PWR,
    OP_OUT_CLZ,
    OP_OUT_NORM,
    OP_OUT_LOG,
    OP_OUT_MUL,
    OP_OUT_LVL
  } dp_op_e;

  typedef struct packed {
    dp_op_e              op;
    logic                in_write;
    logic [AddrW-1:0]    idx;
    logic [StageW-1:0]   stage;
    logic [HalfW-1:0]    bf;
  } dp_cmd_t;

  // quarter wave sine, Q15
  localparam logic [CoefW-1:0] QSin [17] = '{
    17'd0,     17'd3212,  17'd6393,  17'd9512,  17'd12540, 17'd15447,
    17'd18205, 17'd20788, 17'd23170, 17'd25330, 17'd27246, 17'd28899,
    17'd30274, 17'd31357, 17'd32138, 17'd32610, 17'd32768
  };

  function automatic logic signed [CoefW-1:0] cos_q15(input logic [AddrW-1:0] m);
    logic [4:0] r;
    logic [4:0] rc;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    r  = {1'b0, m[3:0]};
    rc = 5'd16 - r;
    a  = QSin[r];
    b  = QSin[rc];
    case (m[5:4])
      2'd0:    cos_q15 = b;
      2'd1:    cos_q15 = -a;
      2'd2:    cos_q15 = -b;
      default: cos_q15 = a;
    endcase
  endfunction

  function automatic logic signed [CoefW-1:0] sin_q15(input logic [AddrW-1:0] m);
    logic [4:0] r;
    logic [4:0] rc;
    logic signed [CoefW-1:0] a;
    logic signed [CoefW-1:0] b;
    r  = {1'b0, m[3:0]};
    rc = 5'd16 - r;
    a  = QSin[r];
    b  = QSin[rc];
    case (m[5:4])
      2'd0:    sin_q15 = a;
      2'd1:    sin_q15 = b;
      2'd2:    sin_q15 = -a;
      default: sin_q15 = -b;
    endcase
  endfunction

  function automatic logic signed [CoefW-1:0] hann_q15(input logic [AddrW-1:0] m);
    logic signed [CoefW:0] c;
    logic signed [CoefW:0] t;
    c = (CoefW + 1)'(cos_q15(m));
    t = 18'sd32769 - c;
    hann_q15 = t[CoefW:1];
  endfunction

  function automatic logic [AddrW-1:0] bit_rev(input logic [AddrW-1:0] v);
    for (int b = 0; b < AddrW; b++) begin
      bit_rev[b] = v[AddrW-1-b];
    end
  endfunction

endpackage

// ===== hdl/stft_waterfall_row_engine.sv =====
// ----------------------------------------------------------------------------
// stft_waterfall_row_engine
// Hann-windowed 64-point FFT spectrogram rows in dB from an I/Q frame stream.
// ----------------------------------------------------------------------------
// Frames are taken one per cycle while no row is in progress. When a row
// fires the block stops taking frames and runs a single shared sequencer:
// windowing of each sample, then 192 radix-2 butterflies, each read, multiplied
// and written back through one work memory write port, then per bin power,
// normalisation and 12 log2 squaring steps, each bin waiting for out_ready.
// Frames are taken again once the last bin leaves.
module stft_waterfall_row_engine import sfwr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] i_sample_i,
  input  logic [SampleBits-1:0] q_sample_i,
  input  logic                  batch_end_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [LevelW-1:0]     level_o,
  output logic [AddrW-1:0]      bin_index_o,
  output logic                  row_last_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [OffW-1:0]       cfg_data_i
);

  dp_cmd_t cmd;

  sfwr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i[HopW-1:0]),
    .cmd_o       (cmd)
  );

  sfwr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .i_sample_i  (i_sample_i),
    .q_sample_i  (q_sample_i),
    .level_o     (level_o),
    .bin_index_o (bin_index_o),
    .row_last_o  (row_last_o)
  );

endmodule

// ===== hdl/sfwr_dp.sv =====
// ----------------------------------------------------------------------------
// sfwr_dp
// Datapath: frame ring, fft work memory, window, butterfly and dB level unit.
// ----------------------------------------------------------------------------
module sfwr_dp import sfwr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [OffW-1:0]       cfg_data_i,
  input  logic [SampleBits-1:0] i_sample_i,
  input  logic [SampleBits-1:0] q_sample_i,
  output logic [LevelW-1:0]     level_o,
  output logic [AddrW-1:0]      bin_index_o,
  output logic                  row_last_o
);

  logic [AddrW-1:0]        slot_q;
  logic [OffW-1:0]         offset_q;

  logic [2*SampleBits-1:0] ring_mem [FftSize];
  logic [2*SampleBits-1:0] ring_rd_q;
  logic [2*WorkW-1:0]      work_mem [FftSize];
  logic [2*WorkW-1:0]      rda_q, rdb_q;

  logic signed [41:0]      p_rc_q, p_is_q, p_ic_q, p_rs_q;
  logic signed [WorkW-1:0] t_re_q, t_im_q;
  logic [PowW-1:0]         pow_q;
  logic                    zero_q;
  logic [ExpW-1:0]         exp_q;
  logic [MantW-1:0]        mant_q;
  logic [FracW-1:0]        frac_q;
  logic [ScaleW-1:0]       scaled_q;
  logic [LevelW-1:0]       level_q;
  logic [AddrW-1:0]        bin_q;
  logic                    last_q;

  // butterfly addressing
  logic [AddrW-1:0] low_mask, addr_a, addr_b, tw_idx, bf_ext;
  assign bf_ext   = AddrW'(cmd_i.bf);
  assign low_mask = (AddrW'(1) << cmd_i.stage) - AddrW'(1);
  assign addr_a   = ((bf_ext >> cmd_i.stage) << (cmd_i.stage + StageW'(1))) | (bf_ext & low_mask);
  assign addr_b   = addr_a | (AddrW'(1) << cmd_i.stage);
  assign tw_idx   = (bf_ext & low_mask) << (StageW'(HalfW) - cmd_i.stage);

  logic signed [CoefW-1:0] tw_c, tw_s, win_w;
  assign tw_c  = cos_q15(tw_idx);
  assign tw_s  = sin_q15(tw_idx);
  assign win_w = hann_q15(cmd_i.idx);

  logic signed [WorkW-1:0] a_re, a_im, b_re, b_im;
  assign a_re = rda_q[2*WorkW-1:WorkW];
  assign a_im = rda_q[WorkW-1:0];
  assign b_re = rdb_q[2*WorkW-1:WorkW];
  assign b_im = rdb_q[WorkW-1:0];

  // windowing, rounded half up
  logic signed [SampleBits-1:0] x_i, x_q;
  logic signed [32:0]           wp_i, wp_q;
  logic signed [WorkW-1:0]      w_re, w_im;
  assign x_i  = ring_rd_q[2*SampleBits-1:SampleBits];
  assign x_q  = ring_rd_q[SampleBits-1:0];
  assign wp_i = x_i * win_w + 33'sd16384;
  assign wp_q = x_q * win_w + 33'sd16384;
  assign w_re = WorkW'($signed(wp_i[32:15]));
  assign w_im = WorkW'($signed(wp_q[32:15]));

  // twiddle product rounding
  logic signed [42:0]      s_re, s_im;
  logic signed [WorkW-1:0] t_re, t_im;
  assign s_re = 43'(p_rc_q) + 43'(p_is_q) + 43'sd16384;
  assign s_im = 43'(p_ic_q) - 43'(p_rs_q) + 43'sd16384;
  assign t_re = s_re[15+WorkW-1:15];
  assign t_im = s_im[15+WorkW-1:15];

  // power
  logic [WorkW-1:0] abs_re, abs_im;
  assign abs_re = a_re[WorkW-1] ? WorkW'(-a_re) : WorkW'(a_re);
  assign abs_im = a_im[WorkW-1] ? WorkW'(-a_im) : WorkW'(a_im);

  logic [ExpW-1:0] lead;
  always_comb begin
    lead = '0;
    for (int b = 0; b < PowW; b++) begin
      if (pow_q[b]) lead = ExpW'(b);
    end
  end

  logic [PowW-1:0] norm;
  assign norm = (exp_q >= ExpW'(30)) ? (pow_q >> (exp_q - ExpW'(30)))
                                     : (pow_q << (ExpW'(30) - exp_q));

  logic [2*MantW-1:0] sq;
  logic [MantW:0]     sq_sh;
  assign sq    = mant_q * mant_q;
  assign sq_sh = sq[2*MantW-1:30];

  // level in units of 2^-32 dB
  logic signed [63:0] t_db, t_rnd;
  assign t_db  = $signed({24'd0, scaled_q}) - DbBase
               + (64'($signed(offset_q)) <<< 32);
  assign t_rnd = t_db + 64'sd2147483648;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      offset_q <= OffReset;
    end else begin
      if (cmd_i.in_write) slot_q <= slot_q + AddrW'(1);
      if (cfg_we_i && cfg_index_i == REG_OFFSET) offset_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_write) ring_mem[slot_q] <= {i_sample_i, q_sample_i};
    if (cmd_i.op == OP_WIN_RD) ring_rd_q <= ring_mem[slot_q + cmd_i.idx];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_WIN_WR: work_mem[bit_rev(cmd_i.idx)] <= {w_re, w_im};
      OP_BF_WRA: work_mem[addr_a] <= {WorkW'(a_re + t_re), WorkW'(a_im + t_im)};
      OP_BF_WRB: work_mem[addr_b] <= {WorkW'(a_re - t_re_q), WorkW'(a_im - t_im_q)};
      default: ;
    endcase
    case (cmd_i.op)
      OP_BF_RD: begin
        rda_q <= work_mem[addr_a];
        rdb_q <= work_mem[addr_b];
      end
      OP_OUT_RD: rda_q <= work_mem[{~cmd_i.idx[AddrW-1], cmd_i.idx[AddrW-2:0]}];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_BF_MUL: begin
        p_rc_q <= b_re * tw_c;
        p_is_q <= b_im * tw_s;
        p_ic_q <= b_im * tw_c;
        p_rs_q <= b_re * tw_s;
      end
      OP_BF_WRA: begin
        t_re_q <= t_re;
        t_im_q <= t_im;
      end
      OP_OUT_PWR: pow_q <= PowW'(abs_re * abs_re) + PowW'(abs_im * abs_im);
      OP_OUT_CLZ: begin
        exp_q  <= lead;
        zero_q <= (pow_q == '0);
      end
      OP_OUT_NORM: begin
        mant_q <= norm[MantW-1:0];
        frac_q <= '0;
      end
      OP_OUT_LOG: begin
        if (sq_sh[MantW]) begin
          mant_q <= sq_sh[MantW:1];
          frac_q <= {frac_q[FracW-2:0], 1'b1};
        end else begin
          mant_q <= sq_sh[MantW-1:0];
          frac_q <= {frac_q[FracW-2:0], 1'b0};
        end
      end
      OP_OUT_MUL: scaled_q <= ScaleW'({exp_q, frac_q} * Db16Q16);
      OP_OUT_LVL: begin
        if (zero_q || t_db <= 64'sd0) begin
          level_q <= '0;
        end else if (t_rnd[63:32] > 32'd255) begin
          level_q <= '1;
        end else begin
          level_q <= t_rnd[32+LevelW-1:32];
        end
        bin_q  <= cmd_i.idx;
        last_q <= (cmd_i.idx == '1);
      end
      default: ;
    endcase
  end

  assign level_o     = level_q;
  assign bin_index_o = bin_q;
  assign row_last_o  = last_q;

endmodule

// ===== hdl/sfwr_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfwr_ctrl
// Controller: frame counting, row trigger and sequencing of the datapath.
// ----------------------------------------------------------------------------
module sfwr_ctrl import sfwr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [HopW-1:0] cfg_data_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_WIN_RD   = 15'b000000000000010,
    S_WIN_WR   = 15'b000000000000100,
    S_BF_RD    = 15'b000000000001000,
    S_BF_MUL   = 15'b000000000010000,
    S_BF_WRA   = 15'b000000000100000,
    S_BF_WRB   = 15'b000000001000000,
    S_OUT_RD   = 15'b000000010000000,
    S_OUT_PWR  = 15'b000000100000000,
    S_OUT_CLZ  = 15'b000001000000000,
    S_OUT_NORM = 15'b000010000000000,
    S_OUT_LOG  = 15'b000100000000000,
    S_OUT_MUL  = 15'b001000000000000,
    S_OUT_LVL  = 15'b010000000000000,
    S_OUT_HOLD = 15'b100000000000000
  } state_e;

  state_e              state_q, state_d;
  logic [AddrW-1:0]    idx_q, idx_d;
  logic [StageW-1:0]   stage_q, stage_d;
  logic [HalfW-1:0]    bf_q, bf_d;
  logic [IterW-1:0]    iter_q, iter_d;
  logic [CntW-1:0]     filled_q, filled_d;
  logic [CntW-1:0]     since_q, since_d;
  logic [HopW-1:0]     hop_q;
  logic                out_valid_q, out_valid_d;

  logic            accept, fire;
  logic [CntW-1:0] filled_nx, since_nx;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign filled_nx   = (filled_q < CntW'(FftSize)) ? filled_q + CntW'(1) : filled_q;
  assign since_nx    = (since_q != '1) ? since_q + CntW'(1) : since_q;
  assign fire        = (filled_nx == CntW'(FftSize)) && (since_nx >= hop_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    stage_d     = stage_q;
    bf_d        = bf_q;
    iter_d      = iter_q;
    filled_d    = filled_q;
    since_d     = since_q;
    out_valid_d = out_valid_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          filled_d = filled_nx;
          since_d  = fire ? '0 : since_nx;
          if (fire) begin
            idx_d   = '0;
            state_d = S_WIN_RD;
          end
        end
      end
      S_WIN_RD: state_d = S_WIN_WR;
      S_WIN_WR: begin
        idx_d = idx_q + AddrW'(1);
        if (idx_q == '1) begin
          stage_d = '0;
          bf_d    = '0;
          state_d = S_BF_RD;
        end else begin
          state_d = S_WIN_RD;
        end
      end
      S_BF_RD:  state_d = S_BF_MUL;
      S_BF_MUL: state_d = S_BF_WRA;
      S_BF_WRA: state_d = S_BF_WRB;
      S_BF_WRB: begin
        bf_d    = bf_q + HalfW'(1);
        state_d = S_BF_RD;
        if (bf_q == '1) begin
          if (stage_q == StageLast) begin
            idx_d   = '0;
            state_d = S_OUT_RD;
          end else begin
            stage_d = stage_q + StageW'(1);
          end
        end
      end
      S_OUT_RD:   state_d = S_OUT_PWR;
      S_OUT_PWR:  state_d = S_OUT_CLZ;
      S_OUT_CLZ:  state_d = S_OUT_NORM;
      S_OUT_NORM: begin
        iter_d  = '0;
        state_d = S_OUT_LOG;
      end
      S_OUT_LOG: begin
        iter_d = iter_q + IterW'(1);
        if (iter_q == LogLast) state_d = S_OUT_MUL;
      end
      S_OUT_MUL: state_d = S_OUT_LVL;
      S_OUT_LVL: begin
        out_valid_d = 1'b1;
        state_d     = S_OUT_HOLD;
      end
      S_OUT_HOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          idx_d       = idx_q + AddrW'(1);
          state_d     = (idx_q == '1) ? S_IDLE : S_OUT_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    case (state_q)
      S_WIN_RD:   cmd_o.op = OP_WIN_RD;
      S_WIN_WR:   cmd_o.op = OP_WIN_WR;
      S_BF_RD:    cmd_o.op = OP_BF_RD;
      S_BF_MUL:   cmd_o.op = OP_BF_MUL;
      S_BF_WRA:   cmd_o.op = OP_BF_WRA;
      S_BF_WRB:   cmd_o.op = OP_BF_WRB;
      S_OUT_RD:   cmd_o.op = OP_OUT_RD;
      S_OUT_PWR:  cmd_o.op = OP_OUT_PWR;
      S_OUT_CLZ:  cmd_o.op = OP_OUT_CLZ;
      S_OUT_NORM: cmd_o.op = OP_OUT_NORM;
      S_OUT_LOG:  cmd_o.op = OP_OUT_LOG;
      S_OUT_MUL:  cmd_o.op = OP_OUT_MUL;
      S_OUT_LVL:  cmd_o.op = OP_OUT_LVL;
      default:    cmd_o.op = OP_NONE;
    endcase
    cmd_o.in_write = accept;
    cmd_o.idx      = idx_q;
    cmd_o.stage    = stage_q;
    cmd_o.bf       = bf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      stage_q     <= '0;
      bf_q        <= '0;
      iter_q      <= '0;
      filled_q    <= '0;
      since_q     <= '0;
      hop_q       <= HopReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      stage_q     <= stage_d;
      bf_q        <= bf_d;
      iter_q      <= iter_d;
      filled_q    <= filled_d;
      since_q     <= since_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && cfg_index_i == REG_HOP) hop_q <= cfg_data_i;
    end
  end

  a_no_input_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input taken while a bin is pending");

  a_since_clear_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (since_q == '0))
    else $error("frame count not cleared for row");

  a_row_needs_full_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WIN_RD && idx_q == '0) |-> (filled_q == CntW'(FftSize)))
    else $error("row started before ring filled");

  a_valid_only_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_OUT_HOLD))
    else $error("bin valid outside hold");

endmodule
